@@ rtl/core/ccurv_pkg.sv @@
// Shared types and constants for the contour curvature block.
package ccurv_pkg;

	localparam int IDX_W      = 12;
	localparam int COORD_W    = 16;
	localparam int CURV_W     = 24;
	localparam int MUL_STEPS  = 16;
	localparam int SQRT_STEPS = 27;
	localparam int DEN_STEPS  = 27;
	localparam int DIV_STEPS  = 24;
	localparam int STEP_W     = 5;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic                      last_point;
	} ccurv_in_t;

	typedef struct packed {
		logic [IDX_W-1:0]  point_index;
		logic [CURV_W-1:0] curvature;
		logic              degenerate;
		logic              last_result;
	} ccurv_out_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} ccurv_point_t;

	// Three consecutive contour points: a before b, c after b
	typedef struct packed {
		ccurv_point_t a;
		ccurv_point_t b;
		ccurv_point_t c;
	} ccurv_job_t;

	typedef struct packed {
		ccurv_job_t       pts;
		logic [IDX_W-1:0] idx;
		logic             last;
	} ccurv_task_t;

	typedef struct packed {
		logic              idle;
		logic              done;
		logic [CURV_W-1:0] curvature;
		logic              degenerate;
	} ccurv_result_t;

endpackage

@@ rtl/core/ccurv_unit.sv @@
// Bit-serial curvature engine: shift-add products, digit square root, restoring divide.
module ccurv_unit import ccurv_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  ccurv_job_t    job,
	input  logic          ack,
	output ccurv_result_t result
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_MUL   = 8'b0000_0010,
		S_CROSS = 8'b0000_0100,
		S_SQRT  = 8'b0000_1000,
		S_DEN   = 8'b0001_0000,
		S_CHECK = 8'b0010_0000,
		S_DIV   = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [STEP_W-1:0] step_q;

	// operand setup
	logic signed [16:0] dx_w, dy_w;
	logic signed [17:0] ex_w, ey_w;
	logic [16:0] ndx_w, ndy_w;
	logic [17:0] nex_w, ney_w;
	logic [15:0] dxm_w, dym_w;
	logic [16:0] exm_w, eym_w;

	// serial multiply registers
	logic [15:0] mplx_q, mply_q, dxm_q, dym_q;
	logic [16:0] exm_q, eym_q;
	logic        sgn1_q, sgn2_q;
	logic [32:0] p1_q, p2_q;
	logic [31:0] p3_q, p4_q;

	// cross and norm
	logic signed [34:0] t1_w, t2_w, cr_w;
	logic [34:0] ncr_w;
	logic [32:0] s_w;
	logic [33:0] x_q;
	logic [32:0] s_q;

	// square root
	logic [53:0] rad_q;
	logic [28:0] rem_q;
	logic [26:0] root_q;
	logic [30:0] rem_t_w;
	logic [30:0] trial_w;

	// denominator and division
	logic [59:0] den_q;
	logic [59:0] drem_q;
	logic [60:0] r2_w;
	logic [60:0] r2_sub_w;
	logic [59:0] xs_w;
	logic [CURV_W-1:0] q_q;
	logic [CURV_W-1:0] curv_q;
	logic              deg_q;

	// differences of the neighbor points
	always_comb begin
		dx_w  = $signed({job.c.x[15], job.c.x}) - $signed({job.a.x[15], job.a.x});
		dy_w  = $signed({job.c.y[15], job.c.y}) - $signed({job.a.y[15], job.a.y});
		ex_w  = $signed({{2{job.c.x[15]}}, job.c.x}) - $signed({job.b.x[15], job.b.x, 1'b0})
		      + $signed({{2{job.a.x[15]}}, job.a.x});
		ey_w  = $signed({{2{job.c.y[15]}}, job.c.y}) - $signed({job.b.y[15], job.b.y, 1'b0})
		      + $signed({{2{job.a.y[15]}}, job.a.y});
		ndx_w = 17'(-dx_w);
		ndy_w = 17'(-dy_w);
		nex_w = 18'(-ex_w);
		ney_w = 18'(-ey_w);
		dxm_w = dx_w[16] ? ndx_w[15:0] : dx_w[15:0];
		dym_w = dy_w[16] ? ndy_w[15:0] : dy_w[15:0];
		exm_w = ex_w[17] ? nex_w[16:0] : ex_w[16:0];
		eym_w = ey_w[17] ? ney_w[16:0] : ey_w[16:0];
	end

	// signed cross product magnitude and squared norm
	always_comb begin
		t1_w  = sgn1_q ? -$signed({2'b00, p1_q}) : $signed({2'b00, p1_q});
		t2_w  = sgn2_q ? -$signed({2'b00, p2_q}) : $signed({2'b00, p2_q});
		cr_w  = t1_w - t2_w;
		ncr_w = 35'(-cr_w);
		s_w   = {1'b0, p3_q} + {1'b0, p4_q};
	end

	// one root bit per step
	always_comb begin
		rem_t_w = {rem_q, rad_q[53:52]};
		trial_w = {2'b00, root_q, 2'b01};
	end

	// one quotient bit per step
	always_comb begin
		r2_w     = {drem_q, 1'b0};
		r2_sub_w = r2_w - {1'b0, den_q};
		xs_w     = {18'b0, x_q, 8'b0};
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_MUL;
						step_q  <= '0;
					end
				end
				S_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(MUL_STEPS - 1)) begin
						state_q <= S_CROSS;
					end
				end
				S_CROSS: begin
					step_q  <= '0;
					state_q <= (s_w == '0) ? S_DONE : S_SQRT;
				end
				S_SQRT: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(SQRT_STEPS - 1)) begin
						state_q <= S_DEN;
						step_q  <= '0;
					end
				end
				S_DEN: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(DEN_STEPS - 1)) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					step_q  <= '0;
					state_q <= (xs_w >= den_q) ? S_DONE : S_DIV;
				end
				S_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (ack) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				mplx_q <= dxm_w;
				mply_q <= dym_w;
				dxm_q  <= dxm_w;
				dym_q  <= dym_w;
				exm_q  <= exm_w;
				eym_q  <= eym_w;
				sgn1_q <= ey_w[17] ^ dx_w[16];
				sgn2_q <= ex_w[17] ^ dy_w[16];
				p1_q   <= '0;
				p2_q   <= '0;
				p3_q   <= '0;
				p4_q   <= '0;
			end
			S_MUL: begin
				p1_q   <= {p1_q[31:0], 1'b0} + (mplx_q[15] ? {16'b0, eym_q} : 33'b0);
				p3_q   <= {p3_q[30:0], 1'b0} + (mplx_q[15] ? {16'b0, dxm_q} : 32'b0);
				p2_q   <= {p2_q[31:0], 1'b0} + (mply_q[15] ? {16'b0, exm_q} : 33'b0);
				p4_q   <= {p4_q[30:0], 1'b0} + (mply_q[15] ? {16'b0, dym_q} : 32'b0);
				mplx_q <= {mplx_q[14:0], 1'b0};
				mply_q <= {mply_q[14:0], 1'b0};
			end
			S_CROSS: begin
				x_q    <= cr_w[34] ? ncr_w[33:0] : cr_w[33:0];
				s_q    <= s_w;
				rad_q  <= {1'b0, s_w, 20'b0};
				rem_q  <= '0;
				root_q <= '0;
				den_q  <= '0;
				curv_q <= '1;
				deg_q  <= 1'b1;
			end
			S_SQRT: begin
				rad_q <= {rad_q[51:0], 2'b00};
				if (rem_t_w >= trial_w) begin
					rem_q  <= 29'(rem_t_w - trial_w);
					root_q <= {root_q[25:0], 1'b1};
				end else begin
					rem_q  <= rem_t_w[28:0];
					root_q <= {root_q[25:0], 1'b0};
				end
			end
			S_DEN: begin
				den_q  <= {den_q[58:0], 1'b0} + (root_q[26] ? {27'b0, s_q} : 60'b0);
				root_q <= {root_q[25:0], 1'b0};
			end
			S_CHECK: begin
				drem_q <= xs_w;
				q_q    <= '0;
			end
			S_DIV: begin
				if (r2_w >= {1'b0, den_q}) begin
					drem_q <= r2_sub_w[59:0];
					q_q    <= {q_q[CURV_W-2:0], 1'b1};
				end else begin
					drem_q <= r2_w[59:0];
					q_q    <= {q_q[CURV_W-2:0], 1'b0};
				end
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					curv_q <= r2_w >= {1'b0, den_q} ? {q_q[CURV_W-2:0], 1'b1}
					                                : {q_q[CURV_W-2:0], 1'b0};
					deg_q  <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	assign result.idle       = (state_q == S_IDLE);
	assign result.done       = (state_q == S_DONE);
	assign result.curvature  = curv_q;
	assign result.degenerate = deg_q;

endmodule

@@ rtl/core/contour_curvature_top.sv @@
// Contour curvature top level: point window, result queue and output register.
//
//  channel | signals                     | payload
//  in      | in_valid / in_ready         | in_data  (ccurv_in_t)
//  out     | out_valid / out_ready       | out_data (ccurv_out_t)
//
// A result passes through the bit-serial engine: start, 16 multiply steps, cross
// product, 27 root steps, 27 denominator steps, range check, 24 divide steps and done;
// a zero neighbor difference ends after the cross product, an overflow skips the divide.
// A point causes up to three results, so a transaction holds the input until the
// engine has finished all of them; points that cause no result are taken every cycle.
// Reset clears the contour window; the next point starts a new contour.
// A stalled output holds the engine in its done state until the register frees.
module contour_curvature_top import ccurv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  ccurv_in_t  in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output ccurv_out_t out_data
);

	ccurv_point_t head0_q, head1_q, win_a_q, win_b_q;
	logic [IDX_W-1:0] cnt_q;
	logic [1:0]       fill_q;

	ccurv_task_t task_q [3];
	ccurv_task_t new_task [3];
	logic [1:0]  task_n_q, task_ptr_q, new_n;

	logic [IDX_W-1:0] cur_idx_q;
	logic             cur_last_q;
	ccurv_out_t       out_q;
	logic             out_valid_q;

	ccurv_point_t  p_w, head1_n;
	ccurv_result_t res;
	logic          start, ack, in_acc;

	function automatic ccurv_task_t mk_task(ccurv_point_t a, ccurv_point_t b,
	                                        ccurv_point_t c, logic [IDX_W-1:0] idx,
	                                        logic last);
		ccurv_task_t t;
		t.pts.a = a;
		t.pts.b = b;
		t.pts.c = c;
		t.idx   = idx;
		t.last  = last;
		return t;
	endfunction

	assign p_w.x   = in_data.point_x;
	assign p_w.y   = in_data.point_y;
	assign head1_n = (fill_q == 2'd1) ? p_w : head1_q;

	// results caused by this point, in output order
	always_comb begin
		new_task = task_q;
		new_n    = '0;
		if (fill_q == 2'd0) begin
			if (in_data.last_point) begin
				new_task[0] = mk_task(p_w, p_w, p_w, '0, 1'b1);
				new_n       = 2'd1;
			end
		end else begin
			if (fill_q == 2'd2) begin
				new_task[0] = mk_task(win_a_q, win_b_q, p_w, cnt_q - 1'b1, 1'b0);
				new_n       = 2'd1;
			end
			if (in_data.last_point) begin
				new_task[new_n]        = mk_task(win_b_q, p_w, head0_q, cnt_q, 1'b0);
				new_task[new_n + 2'd1] = mk_task(p_w, head0_q, head1_n, '0, 1'b1);
				new_n                  = new_n + 2'd2;
			end
		end
	end

	assign in_ready = (task_ptr_q == task_n_q) && res.idle;
	assign in_acc   = in_valid && in_ready;
	assign start    = res.idle && (task_ptr_q != task_n_q);
	assign ack      = res.done && (!out_valid_q || out_ready);

	// contour window and result queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			fill_q     <= '0;
			task_n_q   <= '0;
			task_ptr_q <= '0;
		end else begin
			if (in_acc) begin
				task_n_q   <= new_n;
				task_ptr_q <= '0;
				if (in_data.last_point) begin
					cnt_q  <= '0;
					fill_q <= '0;
				end else begin
					cnt_q  <= cnt_q + 1'b1;
					fill_q <= (fill_q == 2'd2) ? 2'd2 : fill_q + 2'd1;
				end
			end else if (start) begin
				task_ptr_q <= task_ptr_q + 2'd1;
			end
		end
	end

	// point storage and queue payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			task_q <= new_task;
			if (fill_q == 2'd0) begin
				head0_q <= p_w;
				win_b_q <= p_w;
			end else begin
				head1_q <= head1_n;
				win_a_q <= win_b_q;
				win_b_q <= p_w;
			end
		end
		if (start) begin
			cur_idx_q  <= task_q[task_ptr_q].idx;
			cur_last_q <= task_q[task_ptr_q].last;
		end
		if (ack) begin
			out_q.point_index <= cur_idx_q;
			out_q.curvature   <= res.curvature;
			out_q.degenerate  <= res.degenerate;
			out_q.last_result <= cur_last_q;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ack) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	ccurv_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.job    (task_q[task_ptr_q].pts),
		.ack    (ack),
		.result (res)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ rtl/core/ccurv_checker.sv @@
// Port-level checker for the contour curvature block, bound to the top level.
module ccurv_checker import ccurv_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input ccurv_in_t  in_data,
	input logic       out_valid,
	input logic       out_ready,
	input ccurv_out_t out_data
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");

	// flagged results are saturated
	a_deg_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.degenerate |-> out_data.curvature == '1)
		else $error("degenerate result not saturated");

	// closing result of a contour belongs to its first point
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last_result |-> out_data.point_index == '0)
		else $error("last result index not zero");

	// a closing point always starts work
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.last_point |=> !in_ready)
		else $error("input ready right after closing point");

endmodule

bind contour_curvature_top ccurv_checker u_ccurv_checker (.*);
